// File: rtl/xks_pkg.sv
// ----------------------------------------------------------------------------
// XOR key search package
// Types and constants shared by the single-byte XOR key search modules.
// ----------------------------------------------------------------------------
package xks_pkg;

  localparam int PATTERN_LEN = 11;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 1;

  typedef logic [7:0] byte_t;
  typedef logic [PATTERN_LEN-1:0][7:0] window_t;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 1'd1;

  localparam logic [63:0] PATTERN_LOW_RESET  = 64'h6F72_7020_7369_6854;
  localparam logic [23:0] PATTERN_HIGH_RESET = 24'h61_7267;

  localparam byte_t NO_KEY = 8'hFF;

  typedef struct packed {
    byte_t cipher_byte;
    logic  last_byte;
  } in_t;

  typedef struct packed {
    logic  key_found;
    byte_t best_key;
  } out_t;

  // Control of the stage that holds the shifted history.
  typedef struct packed {
    logic valid;
    logic test;
    logic last;
  } stage_ctl_t;

endpackage

// File: rtl/xks_history.sv
// ----------------------------------------------------------------------------
// XOR key search byte history
// Shift register of recent bytes with a saturating fill count; it forms the
// input stage and presents the window to be tested.
// ----------------------------------------------------------------------------
module xks_history #(
  parameter int HISTORY_DEPTH = 18
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  xks_pkg::in_t        in_data,
  input  logic                advance,
  output xks_pkg::window_t    window,
  output xks_pkg::stage_ctl_t ctl
);
  import xks_pkg::*;

  localparam int FILL_W = $clog2(HISTORY_DEPTH);

  byte_t              history [HISTORY_DEPTH];
  logic [FILL_W-1:0]  fill;
  stage_ctl_t         stage;
  logic               accept;
  logic               full;

  assign in_ready = !stage.valid || advance;
  assign accept   = in_valid && in_ready;
  assign full     = (fill >= FILL_W'(HISTORY_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (accept) begin
      history[0] <= in_data.cipher_byte;
      for (int j = 1; j < HISTORY_DEPTH; j++) begin
        history[j] <= history[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      stage <= '0;
    end else begin
      if (accept) begin
        stage.valid <= 1'b1;
        stage.test  <= full;
        stage.last  <= in_data.last_byte;
        if (in_data.last_byte) begin
          fill <= '0;
        end else if (!full) begin
          fill <= fill + 1'b1;
        end
      end else if (advance) begin
        stage.valid <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < PATTERN_LEN; k++) begin
      window[k] = history[HISTORY_DEPTH-1-k];
    end
  end

  assign ctl = stage;

endmodule

// File: rtl/xks_match.sv
// ----------------------------------------------------------------------------
// XOR key search window compare
// XORs the window with the known plaintext and checks that all eleven
// results agree on one key other than the excluded value.
// ----------------------------------------------------------------------------
module xks_match (
  input  xks_pkg::window_t window,
  input  xks_pkg::window_t pattern,
  output logic             hit,
  output xks_pkg::byte_t   cand
);
  import xks_pkg::*;

  logic all_equal;

  assign cand = window[0] ^ pattern[0];

  always_comb begin
    all_equal = 1'b1;
    for (int k = 1; k < PATTERN_LEN; k++) begin
      if ((window[k] ^ pattern[k]) != cand) begin
        all_equal = 1'b0;
      end
    end
  end

  assign hit = all_equal && (cand != NO_KEY);

endmodule

// File: rtl/xks_tracker.sv
// ----------------------------------------------------------------------------
// XOR key search result tracker
// Keeps the smallest key seen in the current stream and loads the result
// register when the final byte of a stream is processed.
// ----------------------------------------------------------------------------
module xks_tracker (
  input  logic                clk,
  input  logic                rst,
  input  xks_pkg::stage_ctl_t ctl,
  input  logic                hit,
  input  xks_pkg::byte_t      cand,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_ready,
  output xks_pkg::out_t       out_data
);
  import xks_pkg::*;

  logic  match_seen;
  byte_t min_key;
  logic  seen_next;
  byte_t min_key_next;
  logic  take;

  assign take    = ctl.valid && (!ctl.last || !out_valid || out_ready);
  assign advance = take;

  always_comb begin
    seen_next    = match_seen;
    min_key_next = min_key;
    if (ctl.test && hit && (!match_seen || cand < min_key)) begin
      seen_next    = 1'b1;
      min_key_next = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_seen <= 1'b0;
      min_key    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (take && ctl.last) begin
        out_valid  <= 1'b1;
        match_seen <= 1'b0;
        min_key    <= '0;
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        if (take) begin
          match_seen <= seen_next;
          min_key    <= min_key_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctl.last) begin
      out_data.key_found <= seen_next;
      out_data.best_key  <= seen_next ? min_key_next : '0;
    end
  end

  // A stream end always leaves a result and a cleared search.
  assert property (@(posedge clk) disable iff (rst)
    take && ctl.last |=> out_valid && !match_seen && (min_key == '0))
    else $error("stream end did not load the result or clear the search");

  // A waiting result is never overwritten by the next stream end.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(take && ctl.last))
    else $error("result overwritten while waiting");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.key_found |-> out_data.best_key == '0)
    else $error("key reported without a match");

  assert property (@(posedge clk) disable iff (rst)
    match_seen |-> min_key != NO_KEY)
    else $error("excluded key recorded as a match");

endmodule

// File: rtl/xor_key_known_plaintext_search_top.sv
// ----------------------------------------------------------------------------
// Single-byte XOR known-plaintext key search
// Finds the smallest single-byte XOR key that reveals an eleven-byte known
// plaintext in a ciphertext stream and reports it at the end of the stream.
// ----------------------------------------------------------------------------
// The block takes one ciphertext byte per cycle unless a stream's final byte
// waits for the previous result to be taken. Each byte is shifted into a
// history register on the cycle it is transferred; on the next cycle the
// oldest eleven bytes are compared with the pattern in eleven parallel byte
// compares. A stream's result is loaded into the output register as its final
// byte leaves the stage and is held until taken; the next stream can start
// immediately. The pattern registers should be written only between streams.
module xor_key_known_plaintext_search_top #(
  parameter int HISTORY_DEPTH = 18
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  xks_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output xks_pkg::out_t                      out_data,
  input  logic                               cfg_wr_en,
  input  logic [xks_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [xks_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import xks_pkg::*;

  logic [63:0] pattern_low;
  logic [23:0] pattern_high;
  window_t     pattern;
  window_t     window;
  stage_ctl_t  ctl;
  logic        advance;
  logic        hit;
  byte_t       cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= PATTERN_LOW_RESET;
      pattern_high <= PATTERN_HIGH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_low  <= cfg_data;
        REG_PATTERN_HIGH: pattern_high <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign pattern = {pattern_high, pattern_low};

  xks_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .window   (window),
    .ctl      (ctl)
  );

  xks_match u_match (
    .window  (window),
    .pattern (pattern),
    .hit     (hit),
    .cand    (cand)
  );

  xks_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .hit       (hit),
    .cand      (cand),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
